/* src/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants for the bounded deque
// Request and status codes, sequencer states and payload field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed payload field widths
  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int TOTAL_W  = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_REM_FRONT = 3'd2,
    MODE_REM_BACK  = 3'd3,
    MODE_SEARCH    = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

/* src/bdq_if.sv */
// ----------------------------------------------------------------------------
// bdq_if: request and result channels of the bounded deque
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_in_if;
  import bdq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface bdq_out_if;
  import bdq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic                      found;
  logic [COUNT_W-1:0]        count;
  logic signed [TOTAL_W-1:0] total;

  modport source (output valid, output status, output found, output count,
                  output total, input ready);
  modport sink   (input valid, input status, input found, input count,
                  input total, output ready);
endinterface

`default_nettype wire

/* src/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/bdq_alu.sv */
// ----------------------------------------------------------------------------
// bdq_alu: shared add/subtract and equality unit
// Updates the running sum and compares a stored entry with the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  bdq_pkg::alu_op_t        op,
  input  logic [DATA_WIDTH-1:0]   op_a,
  input  logic [DATA_WIDTH-1:0]   op_b,
  output logic [DATA_WIDTH-1:0]   res,
  output logic                    eq
);
  import bdq_pkg::*;

  always_comb begin
    case (op)
      ALU_SUB: res = op_a - op_b;
      default: res = op_a + op_b;
    endcase
  end

  assign eq = (op_a == op_b);

endmodule

`default_nettype wire

/* src/bdq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdq_ctrl: request sequencer for the bounded deque
// Holds the front pointer, count and sum, drives the entry store and the
// shared unit, and registers each result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  bdq_in_if.sink                   in_ch,
  bdq_out_if.source                out_ch,
  // entry store
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [DATA_WIDTH-1:0]    ram_wdata,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [DATA_WIDTH-1:0]    ram_rdata,
  // shared unit
  output bdq_pkg::alu_op_t         alu_op,
  output logic [DATA_WIDTH-1:0]    alu_a,
  output logic [DATA_WIDTH-1:0]    alu_b,
  input  logic [DATA_WIDTH-1:0]    alu_res,
  input  logic                     alu_eq
);
  import bdq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(DEPTH);
  localparam logic [PW-1:0] LAST_POS  = PW'(DEPTH - 1);

  // Ring position of the element at a given offset from the front
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(base) + (CW + 1)'(off);
    if (s >= DEPTH_EXT) begin
      s = s - DEPTH_EXT;
    end
    return s[PW-1:0];
  endfunction

  state_t                 state_r, state_nxt;
  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic [DATA_WIDTH-1:0]  value_r, value_nxt;
  logic [PW-1:0]          head_r, head_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [DATA_WIDTH-1:0]  sum_r, sum_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  status_t                status_r, status_nxt;
  logic                   found_r, found_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [COUNT_W-1:0]     out_count_r, out_count_nxt;
  logic [TOTAL_W-1:0]     out_total_r, out_total_nxt;
  logic [PW-1:0]          head_dec;

  assign head_dec = (head_r == '0) ? LAST_POS : head_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    value_r      <= value_nxt;
    idx_r        <= idx_nxt;
    status_r     <= status_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    out_total_r  <= out_total_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    value_nxt      = value_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    idx_nxt        = idx_r;
    status_nxt     = status_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    out_total_nxt  = out_total_r;
    ram_we         = 1'b0;
    ram_waddr      = head_r;
    ram_wdata      = value_r;
    ram_raddr      = head_r;
    alu_op         = ALU_ADD;
    alu_a          = sum_r;
    alu_b          = value_r;

    // free the output register once its result has gone
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt   = in_ch.mode;
          value_nxt  = DATA_WIDTH'(in_ch.value);
          status_nxt = STAT_DONE;
          found_nxt  = 1'b0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        case (mode_r) inside
          MODE_INS_FRONT, MODE_INS_BACK: begin
            if (count_r == DEPTH_CNT) begin
              status_nxt = STAT_FULL;
            end else begin
              ram_we = 1'b1;
              if (mode_r == MODE_INS_FRONT) begin
                ram_waddr = head_dec;
                head_nxt  = head_dec;
              end else begin
                ram_waddr = slot_of(head_r, count_r);
              end
              count_nxt = count_r + 1'b1;
              sum_nxt   = alu_res;
            end
            state_nxt = S_FINISH;
          end
          MODE_REM_FRONT, MODE_REM_BACK: begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
              state_nxt  = S_FINISH;
            end else begin
              if (mode_r == MODE_REM_BACK) begin
                ram_raddr = slot_of(head_r, count_r - 1'b1);
              end
              state_nxt = S_READ;
            end
          end
          MODE_SEARCH: begin
            if (count_r == '0) begin
              state_nxt = S_FINISH;
            end else begin
              idx_nxt   = CW'(1);
              state_nxt = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end

      S_READ: begin
        // drop the removed entry from the sum
        alu_op    = ALU_SUB;
        alu_b     = ram_rdata;
        sum_nxt   = alu_res;
        count_nxt = count_r - 1'b1;
        if (mode_r == MODE_REM_FRONT) begin
          head_nxt = slot_of(head_r, CW'(1));
        end
        state_nxt = S_FINISH;
      end

      S_SCAN: begin
        // read data holds the entry at offset idx_r - 1
        alu_a = ram_rdata;
        if (alu_eq) begin
          found_nxt = 1'b1;
          state_nxt = S_FINISH;
        end else if (idx_r == count_r) begin
          state_nxt = S_FINISH;
        end else begin
          ram_raddr = slot_of(head_r, idx_r);
          idx_nxt   = idx_r + 1'b1;
        end
      end

      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt  = found_r;
          out_count_nxt  = COUNT_W'(count_r);
          out_total_nxt  = TOTAL_W'(sum_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.found  = out_found_r;
  assign out_ch.count  = out_count_r;
  assign out_ch.total  = out_total_r;

  // Only one request in flight: no transfer in the cycle after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while another is in progress");

  // The scan index stays within the held elements
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r != '0 && idx_r <= count_r))
    else $error("search index outside held elements");

  // Count moves only on the update steps of an insertion or removal
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EXEC && state_r != S_READ) |=> $stable(count_r))
    else $error("element count changed outside an update step");

  // A full status is only reported with the store full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && status_r == STAT_FULL) |-> (count_r == DEPTH_CNT))
    else $error("full status with free space");

endmodule

`default_nettype wire

/* src/bounded_deque_with_search.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_search: bounded double-ended queue with linear search
// Ring store of signed words with front/back insert and remove, and search.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one request per transfer: mode (insert front, insert back,
//          remove front, remove back, search) and value.
//   out_ch returns exactly one result per request: status, found flag, the
//          element count and the wrapping sum of held elements afterwards.
//   Requests are handled one at a time; in_ch.ready is high only while the
//   sequencer is idle. An insertion or a rejected request passes through
//   the execute and finish states, a removal through execute, read and
//   finish, and a search through execute, the scan state for each entry
//   examined, and finish; the single read port of the entry store is walked
//   one entry a cycle.
//   Results sit in an output register, so the next request is taken while
//   the previous result waits; a finished request holds until it frees.
//   Reset empties the store (count and sum zero) with no clearing pass;
//   stored words are never read before they are written.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_search #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bdq_in_if.sink    in_ch,
  bdq_out_if.source out_ch
);
  import bdq_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic                  ram_we;
  logic [PW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [PW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  alu_op_t               alu_op;
  logic [DATA_WIDTH-1:0] alu_a;
  logic [DATA_WIDTH-1:0] alu_b;
  logic [DATA_WIDTH-1:0] alu_res;
  logic                  alu_eq;

  bdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bdq_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .op   (alu_op),
    .op_a (alu_a),
    .op_b (alu_b),
    .res  (alu_res),
    .eq   (alu_eq)
  );

  bdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .alu_op    (alu_op),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_res   (alu_res),
    .alu_eq    (alu_eq)
  );

endmodule

`default_nettype wire

/* tb/sv/bdq_checker.sv */
// ----------------------------------------------------------------------------
// bdq_checker: result predictor and comparator for the bounded deque
// Watches both channels, keeps its own ring store, front index, element count
// and wrapping sum, and checks every result against the oldest expectation.
// ----------------------------------------------------------------------------
module bdq_checker #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [bdq_pkg::MODE_W-1:0]   in_mode,
  input  logic [bdq_pkg::VALUE_W-1:0]  in_value,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [bdq_pkg::STATUS_W-1:0] out_status,
  input  logic                         out_found,
  input  logic [bdq_pkg::COUNT_W-1:0]  out_count,
  input  logic [bdq_pkg::TOTAL_W-1:0]  out_total,
  output int                           error_count,
  output int                           pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  typedef struct packed {
    status_t             status;
    logic                found;
    logic [COUNT_W-1:0]  count;
    logic [TOTAL_W-1:0]  total;
  } deque_result_t;

  logic [VALUE_W-1:0] ring_words [DEPTH];
  int                 front_idx;
  int                 held;
  logic [TOTAL_W-1:0] word_sum;

  deque_result_t expected_results [$];
  deque_result_t oldest;

  function automatic deque_result_t apply_request(input logic [MODE_W-1:0] req_mode,
                                                  input logic [VALUE_W-1:0] req_value);
    deque_result_t res;
    int pos;
    res.status = STAT_DONE;
    res.found  = 1'b0;
    case (req_mode) inside
      MODE_INS_FRONT, MODE_INS_BACK: begin
        if (held >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          if (req_mode == MODE_INS_FRONT) begin
            front_idx = (front_idx + DEPTH - 1) % DEPTH;
            pos       = front_idx;
          end else begin
            pos = (front_idx + held) % DEPTH;
          end
          ring_words[pos] = req_value;
          held++;
          word_sum = word_sum + req_value;
        end
      end
      MODE_REM_FRONT, MODE_REM_BACK: begin
        if (held == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          pos      = (req_mode == MODE_REM_FRONT) ? front_idx : (front_idx + held - 1) % DEPTH;
          word_sum = word_sum - ring_words[pos];
          if (req_mode == MODE_REM_FRONT) front_idx = (front_idx + 1) % DEPTH;
          held--;
        end
      end
      MODE_SEARCH: begin
        for (int i = 0; i < held; i++) begin
          if (ring_words[(front_idx + i) % DEPTH] == req_value) res.found = 1'b1;
        end
      end
      default: ;  // unused codes leave everything as it is
    endcase
    res.count = COUNT_W'(held);
    res.total = word_sum;
    return res;
  endfunction

  task automatic report_mismatch(input string field_name, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
    $display("%0t: %s mismatch: expected %0d (0x%h), got %0d (0x%h)",
             $time, field_name, exp_val, exp_val, got_val, got_val);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      front_idx = 0;
      held      = 0;
      word_sum  = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected: status %0d count %0d total 0x%h",
                   $time, out_status, out_count, out_total);
          error_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (out_status !== oldest.status) report_mismatch("status", oldest.status, out_status);
          if (out_found !== oldest.found) report_mismatch("found", oldest.found, out_found);
          if (out_count !== oldest.count) report_mismatch("count", oldest.count, out_count);
          if (out_total !== oldest.total) report_mismatch("total", oldest.total, out_total);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_request(in_mode, in_value));
    end
    pending_count = expected_results.size();
  end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for bounded_deque_with_search
// Directed corner requests, then biased random phases that fill the store to
// full and drain it to empty, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = DEPTH_DEF + 16;
  localparam int PHASE_ITEMS    = 215;
  localparam int NUM_PHASES     = 8;
  localparam int CALM_PHASE     = 2;
  localparam int HOLD_PHASE     = 3;
  localparam int MODE_UNUSED_LO = 5;
  localparam int MODE_UNUSED_HI = 7;

  localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_ONES = 32'hffff_ffff;

  // share of insertions among insert/remove requests, per phase
  localparam int GROW_PCT [NUM_PHASES] = '{85, 15, 50, 90, 10, 60, 85, 15};

  logic clk = 1'b0;
  logic rst_n;
  int   errors;
  int   outstanding;
  int   idle_cycles = 0;
  bit   calm = 1'b0;
  bit   hold_request = 1'b0;
  logic [VALUE_W-1:0] hot_values [8];

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  bounded_deque_with_search uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bdq_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_mode       (in_ch.mode),
    .in_value      (in_ch.value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_status    (out_ch.status),
    .out_found     (out_ch.found),
    .out_count     (out_ch.count),
    .out_total     (out_ch.total),
    .error_count   (errors),
    .pending_count (outstanding)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return hot_values[$urandom_range(0, 7)];
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return VAL_ONES;
        2: return VAL_MAX;
        default: return VAL_MIN;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(input int grow_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    if (r < 25) return MODE_SEARCH;
    if ($urandom_range(0, 99) < grow_pct)
      return $urandom_range(0, 1) ? MODE_INS_BACK : MODE_INS_FRONT;
    return $urandom_range(0, 1) ? MODE_REM_BACK : MODE_REM_FRONT;
  endfunction

  // Offer one request and hold it until the transfer; valid stays high when
  // no gap follows.
  task automatic send_request(input logic [MODE_W-1:0] req_mode,
                              input logic [VALUE_W-1:0] req_value);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.mode  <= req_mode;
    in_ch.value <= req_value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result side: bursts of ready with random stalls, and one long hold-off
  // on request.
  initial begin
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MODE_INS_FRONT;
    in_ch.value <= '0;
    foreach (hot_values[i]) hot_values[i] = $urandom;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: empty store, extremes, wrapping sum, unused codes
    send_request(MODE_SEARCH, 32'd5);
    send_request(MODE_REM_FRONT, VAL_ONES);
    send_request(MODE_REM_BACK, '0);
    send_request(MODE_INS_FRONT, VAL_MAX);
    send_request(MODE_INS_BACK, VAL_MIN);
    send_request(MODE_INS_FRONT, VAL_ONES);
    send_request(MODE_INS_BACK, '0);
    send_request(MODE_SEARCH, VAL_MAX);
    send_request(MODE_SEARCH, VAL_MIN);
    send_request(MODE_SEARCH, '0);
    send_request(MODE_SEARCH, 32'h0000_3039);
    send_request(MODE_W'(MODE_UNUSED_LO), VAL_MAX);
    send_request(MODE_W'(MODE_UNUSED_LO + 1), VAL_MIN);
    send_request(MODE_W'(MODE_UNUSED_HI), VAL_ONES);
    send_request(MODE_REM_FRONT, '0);
    send_request(MODE_REM_BACK, '0);
    send_request(MODE_SEARCH, VAL_ONES);
    send_request(MODE_SEARCH, VAL_MAX);
    send_request(MODE_REM_FRONT, '0);
    send_request(MODE_REM_BACK, '0);
    send_request(MODE_REM_BACK, VAL_MAX);
    send_request(MODE_SEARCH, VAL_ONES);
    wait_drained();

    // Biased phases: grow to full, shrink to empty, and random walks
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      calm = (phase == CALM_PHASE);
      if (phase == HOLD_PHASE) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 5) hot_values[$urandom_range(0, 7)] = $urandom;
        send_request(pick_mode(GROW_PCT[phase]), pick_value());
      end
      wait_drained();
    end
    calm = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* bounded_deque_with_search.f */
src/bdq_pkg.sv
src/bdq_if.sv
src/bdq_ram.sv
src/bdq_alu.sv
src/bdq_ctrl.sv
src/bounded_deque_with_search.sv
tb/sv/bdq_checker.sv
tb/sv/testbench.sv
